>>> src/aavr_pkg.sv
`default_nettype none
package aavr_pkg;

	localparam int unsigned CORDIC_STEPS_DEF = 16;
	localparam int unsigned ATAN_ENTRIES = 24;

	localparam logic signed [33:0] PI_Q28      = 34'sd843314857;
	localparam logic signed [33:0] TWO_PI_Q28  = 34'sd1686629713;
	localparam logic signed [33:0] HALF_PI_Q28 = 34'sd421657428;
	localparam logic signed [31:0] ONE_Q28     = 32'sd268435456;
	localparam logic signed [31:0] GAIN_Q28    = 32'sd163008219;

	typedef struct packed {
		logic signed [31:0] vec_x;
		logic signed [31:0] vec_y;
		logic signed [31:0] vec_z;
		logic signed [15:0] axis_x;
		logic signed [15:0] axis_y;
		logic signed [15:0] axis_z;
		logic signed [15:0] turn_angle;
	} in_t;

	typedef struct packed {
		logic signed [31:0] rot_x;
		logic signed [31:0] rot_y;
		logic signed [31:0] rot_z;
	} out_t;

	// data handed from one CORDIC cell to the next
	typedef struct packed {
		logic               neg;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		in_t                item;
	} cord_t;

	function automatic logic signed [31:0] atan_q28(input logic [4:0] i);
		logic signed [31:0] r;
		case (i)
			5'd0:  r = 32'sd210828714;
			5'd1:  r = 32'sd124459457;
			5'd2:  r = 32'sd65760959;
			5'd3:  r = 32'sd33381290;
			5'd4:  r = 32'sd16755422;
			5'd5:  r = 32'sd8385879;
			5'd6:  r = 32'sd4193963;
			5'd7:  r = 32'sd2097109;
			5'd8:  r = 32'sd1048571;
			5'd9:  r = 32'sd524287;
			5'd10: r = 32'sd262144;
			5'd11: r = 32'sd131072;
			5'd12: r = 32'sd65536;
			5'd13: r = 32'sd32768;
			5'd14: r = 32'sd16384;
			5'd15: r = 32'sd8192;
			5'd16: r = 32'sd4096;
			5'd17: r = 32'sd2048;
			5'd18: r = 32'sd1024;
			5'd19: r = 32'sd512;
			5'd20: r = 32'sd256;
			5'd21: r = 32'sd128;
			5'd22: r = 32'sd64;
			5'd23: r = 32'sd32;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> src/aavr_cell.sv
`default_nettype none
module aavr_cell #(
	parameter int unsigned STEP = 0
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire logic           vld,
	input  wire aavr_pkg::cord_t dat,
	output logic                vld_q,
	output aavr_pkg::cord_t     dat_q
);
	import aavr_pkg::*;

	localparam logic signed [31:0] ATAN = atan_q28(5'(STEP));

	logic signed [31:0] dx;
	logic signed [31:0] dy;
	cord_t nxt;

	assign dx = dat.y >>> STEP;
	assign dy = dat.x >>> STEP;

	always_comb begin
		nxt = dat;
		if (!dat.z[31]) begin
			nxt.x = dat.x - dx;
			nxt.y = dat.y + dy;
			nxt.z = dat.z - ATAN;
		end else begin
			nxt.x = dat.x + dx;
			nxt.y = dat.y - dy;
			nxt.z = dat.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_q <= nxt;
		end
	end

endmodule
`default_nettype wire

>>> src/axis_angle_vector_rotate.sv
// Axis-angle vector rotation.
// Input channel item_valid/item_ready/item carries one word: vector (Q16.16),
// axis (Q2.14, used unnormalized) and angle (Q4.12 radians). Output channel
// res_valid/res_ready/res carries the rotated vector, saturated to 32 bits.
// Stages: one angle reduction stage, one CORDIC cell per iteration (at most
// 24 iterations), four matrix/product stages and the output register.
// Throughput is one word per cycle while the output is not stalled; words are
// independent and the pipeline holds up to min(CORDIC_STEPS, 24) + 6 of them.
// The whole pipeline advances when the output register is empty or taken;
// while res_valid is high and res_ready low everything holds and item_ready
// is low. item_ready is high whenever the output register is empty.
// Reset clears all valid flags; no word is in flight afterwards.
`default_nettype none
module axis_angle_vector_rotate #(
	parameter int unsigned CORDIC_STEPS = aavr_pkg::CORDIC_STEPS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire aavr_pkg::in_t item,
	output logic            res_valid,
	input  wire logic       res_ready,
	output aavr_pkg::out_t  res
);
	import aavr_pkg::*;

	localparam int unsigned N = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

	logic en;
	assign en = !res_valid || res_ready;
	assign item_ready = en;

	// angle reduction and folding
	logic signed [33:0] ang0, ang1, ang2;
	logic               neg;
	cord_t              red;

	always_comb begin
		ang0 = 34'(signed'(item.turn_angle)) <<< 16;
		ang1 = ang0;
		if (ang1 > PI_Q28) ang1 = ang1 - TWO_PI_Q28;
		if (ang1 < -PI_Q28) ang1 = ang1 + TWO_PI_Q28;
		ang2 = ang1;
		neg = 1'b0;
		if (ang1 > HALF_PI_Q28) begin
			ang2 = ang1 - PI_Q28;
			neg = 1'b1;
		end else if (ang1 < -HALF_PI_Q28) begin
			ang2 = ang1 + PI_Q28;
			neg = 1'b1;
		end
		red.neg  = neg;
		red.x    = GAIN_Q28;
		red.y    = 32'sd0;
		red.z    = ang2[31:0];
		red.item = item;
	end

	logic  vld_c [0:N];
	cord_t dat_c [0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_c[0] <= 1'b0;
		end else if (en) begin
			vld_c[0] <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dat_c[0] <= red;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		aavr_cell #(.STEP(i)) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.vld   (vld_c[i]),
			.dat   (dat_c[i]),
			.vld_q (vld_c[i+1]),
			.dat_q (dat_c[i+1])
		);
	end

	// matrix build: products order 00, 11, 22, 01, 02, 12
	cord_t              cd;
	logic signed [31:0] cs, sn;
	logic signed [15:0] ax [0:2];
	assign cd = dat_c[N];
	assign cs = cd.neg ? -cd.x : cd.x;
	assign sn = cd.neg ? -cd.y : cd.y;
	assign ax[0] = cd.item.axis_x;
	assign ax[1] = cd.item.axis_y;
	assign ax[2] = cd.item.axis_z;

	logic               vld_s2, vld_s3, vld_s4, vld_s5;
	logic signed [31:0] omc_s2, c24_s2, c24_s3;
	logic signed [31:0] sa_s2 [0:2];
	logic signed [31:0] sa_s3 [0:2];
	logic signed [31:0] aa_s2 [0:5];
	logic signed [31:0] t_s3  [0:5];
	logic signed [31:0] m_s4  [0:8];
	logic signed [63:0] p_s5  [0:8];
	logic signed [31:0] v_s2 [0:2];
	logic signed [31:0] v_s3 [0:2];
	logic signed [31:0] v_s4 [0:2];

	logic signed [47:0] sap [0:2];
	logic signed [63:0] tp  [0:5];
	logic signed [31:0] cr;
	assign cr = (cs + 32'sd8) >>> 4;
	for (genvar k = 0; k < 3; k++) begin : g_sa
		assign sap[k] = ((48'(ax[k]) * 48'(sn)) + 48'sd131072) >>> 18;
	end
	for (genvar k = 0; k < 6; k++) begin : g_t
		assign tp[k] = ((64'(aa_s2[k]) * 64'(omc_s2)) + 64'sd2147483648) >>> 32;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			res_valid <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_c[N];
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			res_valid <= vld_s5;
		end
	end

	logic signed [65:0] acc [0:2];
	logic signed [41:0] rs  [0:2];
	logic signed [31:0] sat [0:2];
	for (genvar r = 0; r < 3; r++) begin : g_out
		assign acc[r] = 66'(p_s5[3*r]) + 66'(p_s5[3*r+1]) + 66'(p_s5[3*r+2])
			+ 66'sd8388608;
		assign rs[r] = 42'(acc[r] >>> 24);
		assign sat[r] = (rs[r] > 42'sd2147483647) ? 32'sh7fffffff :
			(rs[r] < -42'sd2147483648) ? 32'sh80000000 : rs[r][31:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			omc_s2 <= ONE_Q28 - cs;
			c24_s2 <= cr;
			for (int k = 0; k < 3; k++) sa_s2[k] <= sap[k][31:0];
			aa_s2[0] <= 32'(ax[0] * ax[0]);
			aa_s2[1] <= 32'(ax[1] * ax[1]);
			aa_s2[2] <= 32'(ax[2] * ax[2]);
			aa_s2[3] <= 32'(ax[0] * ax[1]);
			aa_s2[4] <= 32'(ax[0] * ax[2]);
			aa_s2[5] <= 32'(ax[1] * ax[2]);
			v_s2[0] <= cd.item.vec_x;
			v_s2[1] <= cd.item.vec_y;
			v_s2[2] <= cd.item.vec_z;

			for (int k = 0; k < 6; k++) t_s3[k] <= tp[k][31:0];
			c24_s3 <= c24_s2;
			sa_s3 <= sa_s2;
			v_s3 <= v_s2;

			m_s4[0] <= t_s3[0] + c24_s3;
			m_s4[1] <= t_s3[3] - sa_s3[2];
			m_s4[2] <= t_s3[4] + sa_s3[1];
			m_s4[3] <= t_s3[3] + sa_s3[2];
			m_s4[4] <= t_s3[1] + c24_s3;
			m_s4[5] <= t_s3[5] - sa_s3[0];
			m_s4[6] <= t_s3[4] - sa_s3[1];
			m_s4[7] <= t_s3[5] + sa_s3[0];
			m_s4[8] <= t_s3[2] + c24_s3;
			v_s4 <= v_s3;

			for (int k = 0; k < 9; k++) p_s5[k] <= 64'(m_s4[k]) * 64'(v_s4[k % 3]);

			res.rot_x <= sat[0];
			res.rot_y <= sat[1];
			res.rot_z <= sat[2];
		end
	end

endmodule
`default_nettype wire

>>> src/aavr_checker.sv
`default_nettype none
module aavr_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       item_ready,
	input wire aavr_pkg::out_t res,
	input wire logic       res_valid,
	input wire logic       res_ready
);
	import aavr_pkg::*;

	// a stalled result word stays
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid) else $error("result word dropped");
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res)) else $error("result word changed");
	// an empty output register never blocks input
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> item_ready) else $error("input blocked while output empty");
	// stall propagates back to input
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !item_ready) else $error("input taken during stall");

endmodule

bind axis_angle_vector_rotate aavr_checker u_aavr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.item_ready(item_ready),
	.res       (res),
	.res_valid (res_valid),
	.res_ready (res_ready)
);
`default_nettype wire
